// ===== design/mbdd_pkg.sv =====
// shared types and constants of the bus datagram decoder
package mbdd_pkg;

    // datagram type bytes
    localparam logic [7:0] T_WIND_KEY  = 8'h86;
    localparam logic [7:0] T_PILOT     = 8'h84;
    localparam logic [7:0] T_STW       = 8'h20;
    localparam logic [7:0] T_DEPTH     = 8'h00;
    localparam logic [7:0] T_TRIP      = 8'h25;
    localparam logic [7:0] T_AWS       = 8'h11;
    localparam logic [7:0] T_AWA       = 8'h10;
    localparam logic [7:0] T_COG       = 8'h53;
    localparam logic [7:0] T_SOG       = 8'h52;
    localparam logic [7:0] T_NAV       = 8'h85;
    localparam logic [7:0] T_XTE       = 8'hAC;

    // key codes of the wind mode adjust datagram
    localparam logic [7:0] K_PLUS_1    = 8'h05;
    localparam logic [7:0] K_PLUS_10   = 8'h06;
    localparam logic [7:0] K_PLUS_90   = 8'h21;
    localparam logic [7:0] K_MINUS_1   = 8'h07;
    localparam logic [7:0] K_MINUS_10  = 8'h08;
    localparam logic [7:0] K_MINUS_90  = 8'h22;

    // pilot modes
    localparam logic [1:0] M_STANDBY   = 2'd0;
    localparam logic [1:0] M_AUTO      = 2'd1;
    localparam logic [1:0] M_WIND      = 2'd2;
    localparam logic [1:0] M_TRACK     = 2'd3;

    // quantity codes
    localparam logic [4:0] Q_MODE      = 5'd0;
    localparam logic [4:0] Q_DIR       = 5'd1;
    localparam logic [4:0] Q_RUDDER    = 5'd2;
    localparam logic [4:0] Q_HEADING   = 5'd3;
    localparam logic [4:0] Q_CTS       = 5'd4;
    localparam logic [4:0] Q_ALARM     = 5'd5;
    localparam logic [4:0] Q_STW       = 5'd6;
    localparam logic [4:0] Q_DEPTH     = 5'd7;
    localparam logic [4:0] Q_TRIP      = 5'd8;
    localparam logic [4:0] Q_AWS       = 5'd9;
    localparam logic [4:0] Q_AWA       = 5'd10;
    localparam logic [4:0] Q_COG       = 5'd11;
    localparam logic [4:0] Q_SOG       = 5'd12;
    localparam logic [4:0] Q_XTE_VALID = 5'd13;
    localparam logic [4:0] Q_BTW       = 5'd14;
    localparam logic [4:0] Q_BTW_VALID = 5'd15;
    localparam logic [4:0] Q_DTW       = 5'd16;
    localparam logic [4:0] Q_XTE       = 5'd17;
    localparam logic [4:0] Q_WTS       = 5'd18;

    localparam int FRAME_BYTES_DEF   = 18;
    localparam int AVERAGE_DEPTH_DEF = 5;

    localparam int EXP_W   = 5;   // datagram length, at most 18
    localparam int ANGLE_W = 15;  // one wind angle sample
    localparam int SUM_W   = 19;  // running sum of up to 16 samples
    localparam int WTS_W   = 17;  // signed wind angle to steer
    localparam int CNT_RW  = 3;   // results per datagram, at most 6

    // depth: round(raw * 3077 / 100) as ((raw * 3077 + 50) * DEP_M) >> DEP_S
    localparam int DEP_P_W = 28;
    localparam int DEP_S   = 35;
    localparam longint DEP_M = ((64'd1 << DEP_S) + 64'd99) / 64'd100;
    localparam int DEP_M_W = 29;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       command_bit;
    } t_in;

    typedef struct packed {
        logic [4:0]         quantity;
        logic signed [23:0] value;
        logic               last;
    } t_out;

    // everything the emitter needs for one completed datagram
    typedef struct packed {
        logic [4:0]                base;
        logic [CNT_RW-1:0]         count;
        logic [7:1][7:0]           b;
        logic [1:0]                mode;
        logic signed [WTS_W-1:0]   wts;
        logic [SUM_W-1:0]          wsum;
        logic [DEP_P_W-1:0]        depth_p;
        logic                      tev;
    } t_job;

endpackage

// ===== design/mbdd_framer.sv =====
// character framing, decoder state and per-datagram job capture
module mbdd_framer #(
    parameter int FRAME_BYTES   = mbdd_pkg::FRAME_BYTES_DEF,
    parameter int AVERAGE_DEPTH = mbdd_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mbdd_pkg::t_in i_data,
    input  logic          i_job_free,
    output logic          o_job_valid,
    output mbdd_pkg::t_job o_job
);
    import mbdd_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int BIX_W = $clog2(FRAME_BYTES);
    localparam int RIX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

    logic [7:0]               r_buf [FRAME_BYTES];
    logic [CNT_W-1:0]         r_count;
    logic [EXP_W-1:0]         r_exp;
    logic                     r_in_frame;
    logic [1:0]               r_mode;
    logic signed [WTS_W-1:0]  r_wts;
    logic [ANGLE_W-1:0]       r_lwa;
    logic [ANGLE_W-1:0]       r_ring [AVERAGE_DEPTH];
    logic [RIX_W-1:0]         r_ridx;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_tev;

    logic [7:0]               w_b [8];
    logic [CNT_W-1:0]         w_next_cnt;
    logic                     w_room;
    logic                     w_completes;
    logic                     w_accept;
    logic                     w_emit;
    logic                     w_unknown;
    logic [1:0]               n_mode;
    logic signed [WTS_W-1:0]  n_wts;
    logic signed [WTS_W:0]    w_t;
    logic signed [WTS_W:0]    w_d;
    logic [ANGLE_W-1:0]       w_angle;
    logic [SUM_W-1:0]         n_sum;
    logic                     n_tev;
    logic [15:0]              w_raw;
    t_job                     w_job;

    assign w_next_cnt  = r_count + CNT_W'(1);
    assign w_room      = (r_count < CNT_W'(FRAME_BYTES));
    assign w_completes = !i_data.command_bit && r_in_frame && w_room
                         && (6'(w_next_cnt) == 6'(r_exp)) && (r_exp > EXP_W'(2));
    assign o_stall     = w_completes && !i_job_free;
    assign w_accept    = i_valid && !o_stall;

    // buffer as it stands once the incoming byte is written
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_b[k] = (r_count == CNT_W'(k)) ? i_data.rx_byte : r_buf[k];
        end
    end

    assign w_angle = {w_b[2], w_b[3][7:1]};
    assign w_raw   = {w_b[4], w_b[3]};

    always_comb begin
        n_mode    = r_mode;
        n_wts     = r_wts;
        n_sum     = r_sum;
        n_tev     = r_tev;
        w_emit    = 1'b1;
        w_unknown = 1'b0;
        w_d       = '0;
        w_t       = '0;
        w_job         = '0;
        w_job.base    = Q_MODE;
        w_job.count   = CNT_RW'(1);
        unique case (w_b[0])
            T_WIND_KEY: begin
                w_job.base = Q_WTS;
                if (r_mode == M_WIND) begin
                    case (w_b[2])
                        K_PLUS_1:   w_d = (WTS_W+1)'(1);
                        K_PLUS_10:  w_d = (WTS_W+1)'(10);
                        K_PLUS_90:  w_d = (WTS_W+1)'(90);
                        K_MINUS_1:  w_d = -(WTS_W+1)'(1);
                        K_MINUS_10: w_d = -(WTS_W+1)'(10);
                        K_MINUS_90: w_d = -(WTS_W+1)'(90);
                        default:    w_d = '0;
                    endcase
                    w_t = (WTS_W+1)'(r_wts) + w_d;
                    if (w_t > (WTS_W+1)'(360)) w_t = w_t - (WTS_W+1)'(360);
                    if (w_t < 0) w_t = w_t + (WTS_W+1)'(360);
                    n_wts = WTS_W'(w_t);
                end
            end
            T_PILOT: begin
                w_job.count = CNT_RW'(6);
                if (!w_b[4][1])     n_mode = M_STANDBY;
                else if (w_b[4][2]) n_mode = M_WIND;
                else if (w_b[4][3]) n_mode = M_TRACK;
                else                n_mode = M_AUTO;
                if (n_mode == M_WIND && r_mode != M_WIND) begin
                    n_wts = WTS_W'(r_lwa);
                end
            end
            T_STW:   w_job.base = Q_STW;
            T_DEPTH: w_job.base = Q_DEPTH;
            T_TRIP:  w_job.base = Q_TRIP;
            T_AWS:   w_job.base = Q_AWS;
            T_AWA: begin
                w_job.base = Q_AWA;
                // running sum: drop the overwritten sample, add the new one
                n_sum = r_sum - SUM_W'(r_ring[r_ridx]) + SUM_W'(w_angle);
            end
            T_COG: w_job.base = Q_COG;
            T_SOG: w_job.base = Q_SOG;
            T_NAV: begin
                w_job.base  = Q_XTE_VALID;
                w_job.count = CNT_RW'(4);
                n_tev       = w_b[6][0];
            end
            T_XTE: begin
                w_job.base = Q_XTE;
                w_emit     = r_tev;
            end
            default: begin
                w_emit    = 1'b0;
                w_unknown = 1'b1;
            end
        endcase
        for (int k = 1; k < 8; k++) begin
            w_job.b[k] = w_b[k];
        end
        w_job.mode    = n_mode;
        w_job.wts     = n_wts;
        w_job.wsum    = n_sum;
        w_job.depth_p = DEP_P_W'(w_raw) * DEP_P_W'(3077) + DEP_P_W'(50);
        w_job.tev     = n_tev;
    end

    assign o_job_valid = w_accept && w_completes && w_emit;
    assign o_job       = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAME_BYTES; k++) r_buf[k] <= '0;
            for (int k = 0; k < AVERAGE_DEPTH; k++) r_ring[k] <= '0;
            r_count    <= '0;
            r_exp      <= '0;
            r_in_frame <= 1'b0;
            r_mode     <= M_STANDBY;
            r_wts      <= '0;
            r_lwa      <= '0;
            r_ridx     <= '0;
            r_sum      <= '0;
            r_tev      <= 1'b0;
        end else if (w_accept) begin
            if (i_data.command_bit) begin
                r_buf[0]   <= i_data.rx_byte;
                r_count    <= CNT_W'(1);
                r_exp      <= '0;
                r_in_frame <= 1'b1;
            end else if (r_in_frame && w_room) begin
                r_buf[r_count[BIX_W-1:0]] <= i_data.rx_byte;
                r_count <= w_next_cnt;
                if (r_count == CNT_W'(1)) begin
                    r_exp <= EXP_W'(i_data.rx_byte[3:0]) + EXP_W'(3);
                end
                if (w_completes) begin
                    r_count    <= '0;
                    r_exp      <= '0;
                    r_in_frame <= 1'b0;
                    r_mode     <= n_mode;
                    r_wts      <= n_wts;
                    r_tev      <= n_tev;
                    if (w_b[0] == T_AWA) begin
                        r_lwa          <= w_angle;
                        r_ring[r_ridx] <= w_angle;
                        r_sum          <= n_sum;
                        r_ridx <= (r_ridx == RIX_W'(AVERAGE_DEPTH - 1)) ? '0
                                  : r_ridx + RIX_W'(1);
                    end
                    if (w_unknown) begin
                        for (int k = 0; k < FRAME_BYTES; k++) begin
                            if (6'(k) < 6'(w_next_cnt)) r_buf[k] <= '0;
                        end
                    end
                end
            end
        end
    end

    a_stall_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_frame && !i_data.command_bit))
        else $error("stall raised on a byte that cannot end a datagram");
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_BYTES))
        else $error("byte count past the buffer");
    a_frame_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_completes) |=> (!r_in_frame && r_count == '0))
        else $error("framer did not return to idle after a datagram");

endmodule

// ===== design/mbdd_emitter.sv =====
// job register, per-result value selection and output register
module mbdd_emitter #(
    parameter int AVERAGE_DEPTH = mbdd_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  mbdd_pkg::t_job i_job,
    output logic           o_job_free,
    output logic           o_valid,
    input  logic           i_stall,
    output mbdd_pkg::t_out o_data
);
    import mbdd_pkg::*;

    localparam int AVG_L = $clog2(AVERAGE_DEPTH);
    localparam int AVG_S = SUM_W + AVG_L;
    localparam longint AVG_M = ((64'd1 << AVG_S) + 64'(AVERAGE_DEPTH) - 64'd1)
                               / 64'(AVERAGE_DEPTH);
    localparam int AVG_M_W = SUM_W + 2;

    t_job              r_job;
    logic              r_job_valid;
    logic [CNT_RW-1:0] r_idx;
    t_out              r_out;
    logic              r_out_valid;

    logic               w_out_free;
    logic               w_last;
    logic [4:0]         w_q;
    logic signed [23:0] w_val;
    logic [SUM_W+AVG_M_W-1:0]   w_avg_p;
    logic [SUM_W-1:0]           w_avg;
    logic [DEP_P_W+DEP_M_W-1:0] w_dep_p;
    logic [9:0]         w_hdg;
    logic [11:0]        w_dist;
    logic [15:0]        w_xte;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_last     = (r_idx == r_job.count - CNT_RW'(1));
    assign o_job_free = !r_job_valid || (w_out_free && w_last);
    assign w_q        = r_job.base + 5'(r_idx);

    // constant divisions by reciprocal multiplication
    assign w_avg_p = r_job.wsum * AVG_M_W'(AVG_M);
    assign w_avg   = SUM_W'(w_avg_p >> AVG_S);
    assign w_dep_p = r_job.depth_p * DEP_M_W'(DEP_M);

    assign w_hdg  = 10'(r_job.b[1][5:4]) * 10'd90 + 10'({r_job.b[2][5:0], 1'b0})
                    + 10'(r_job.b[1][6]);
    assign w_dist = {r_job.b[5], r_job.b[4][7:4]};
    assign w_xte  = {r_job.b[3], r_job.b[2]};

    always_comb begin
        case (w_q)
            Q_MODE:    w_val = 24'(r_job.mode);
            Q_DIR: begin
                if (r_job.mode == M_STANDBY) w_val = '0;
                else if (r_job.b[1][7])      w_val = 24'sd1;
                else                         w_val = -24'sd1;
            end
            Q_RUDDER:  w_val = {{16{r_job.b[6][7]}}, r_job.b[6]};
            Q_HEADING: w_val = (w_hdg > 10'd360) ? '0 : 24'(w_hdg);
            Q_CTS:     w_val = 24'(10'(r_job.b[2][7:6]) * 10'd90)
                               + 24'(r_job.b[3][7:1]);
            Q_ALARM: begin
                if (r_job.b[7][3])      w_val = 24'sd3;
                else if (r_job.b[5][3]) w_val = 24'sd2;
                else if (r_job.b[5][2]) w_val = 24'sd1;
                else                    w_val = '0;
            end
            Q_STW, Q_SOG: w_val = 24'({r_job.b[3], r_job.b[2]});
            Q_DEPTH:   w_val = 24'(w_dep_p[DEP_S +: 22]);
            Q_TRIP:    w_val = 24'({r_job.b[6][3:0], r_job.b[5], r_job.b[4]});
            Q_AWS:     w_val = 24'({r_job.b[2][6:0], 1'b0}) + 24'(r_job.b[3][3:0]);
            Q_AWA:     w_val = (w_avg > SUM_W'(360)) ? '0 : 24'(w_avg);
            Q_COG:     w_val = 24'(w_hdg - 10'(r_job.b[1][6])) + 24'(r_job.b[1][7]);
            Q_XTE_VALID: w_val = 24'(r_job.tev);
            Q_BTW:     w_val = 24'(10'(r_job.b[3][1:0]) * 10'd90)
                               + 24'({r_job.b[4][3:0], r_job.b[3][7:5]});
            Q_BTW_VALID: w_val = 24'(r_job.b[6][1]);
            Q_DTW: begin
                // tenths scale unless the flag says hundredths
                if (r_job.b[6][4]) w_val = 24'(w_dist);
                else               w_val = 24'({w_dist, 3'b000}) + 24'({w_dist, 1'b0});
            end
            Q_XTE:     w_val = r_job.b[1][4] ? 24'(w_xte) : -24'(w_xte);
            Q_WTS:     w_val = 24'(r_job.wts);
            default:   w_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (w_out_free) r_out_valid <= 1'b0;
            if (r_job_valid && w_out_free) begin
                r_out.quantity <= w_q;
                r_out.value    <= w_val;
                r_out.last     <= w_last;
                r_out_valid    <= 1'b1;
                r_idx          <= r_idx + CNT_RW'(1);
                if (w_last) r_job_valid <= 1'b0;
            end
            if (i_job_valid) begin
                r_job       <= i_job;
                r_job_valid <= 1'b1;
                r_idx       <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_job_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> o_job_free)
        else $error("job loaded over an unfinished one");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx < r_job.count))
        else $error("result index past the job's result count");
    a_job_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && w_out_free) |=> r_out_valid)
        else $error("pending result not moved to the output register");

endmodule

// ===== design/marine_bus_datagram_decoder_unit.sv =====
// top level of the nine-bit bus datagram decoder
// input channel: one bus character per transfer (data byte plus command bit);
//   a command character opens a datagram, the low nibble of the second byte
//   plus three gives its length
// output channel: quantity/value results, last set on the final result of a
//   datagram; a datagram gives zero to six results
// result path: a completed datagram is captured in the job register, then its
//   results pass through the output register one per cycle unless stalled
// throughput: one character per cycle; the final character of a datagram is
//   held off only while the previous datagram still has results not yet
//   moved to the output register
// reset: clears framing, pilot mode, wind state and the frame buffer; no
//   result is pending afterwards
// receiver stall: the output register holds its result and the job register
//   holds the rest of the list; other characters keep being taken
module marine_bus_datagram_decoder_unit #(
    parameter int FRAME_BYTES   = mbdd_pkg::FRAME_BYTES_DEF,
    parameter int AVERAGE_DEPTH = mbdd_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mbdd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output mbdd_pkg::t_out o_data
);
    import mbdd_pkg::*;

    logic w_job_valid;
    logic w_job_free;
    t_job w_job;

    mbdd_framer #(
        .FRAME_BYTES  (FRAME_BYTES),
        .AVERAGE_DEPTH(AVERAGE_DEPTH)
    ) u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_job_free (w_job_free),
        .o_job_valid(w_job_valid),
        .o_job      (w_job)
    );

    mbdd_emitter #(
        .AVERAGE_DEPTH(AVERAGE_DEPTH)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job      (w_job),
        .o_job_free (w_job_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule
